FILE: rtl/core/tlc_pkg.sv
// ============================================================================
// tlc_pkg
// Shared types, widths, coefficient tables and decode functions for the
// ultrasonic tank level compensation pipeline.
// ============================================================================
`default_nettype none

package tlc_pkg;

    // ------------------------------------------------------------------
    // Field widths
    // ------------------------------------------------------------------
    localparam int HW_W       = 7;
    localparam int TEMP_W     = 7;
    localparam int RAW_W      = 14;
    localparam int ECHO_W     = 17;
    localparam int KIND_W     = 4;
    localparam int BUTANE_W   = 7;
    localparam int CFG_DATA_W = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int LEVEL_W    = 20;
    localparam int STATUS_W   = 2;

    // ------------------------------------------------------------------
    // Datapath widths (coefficients are fixed point, 40 fraction bits)
    // ------------------------------------------------------------------
    localparam int C0_W     = 41;                 // signed
    localparam int C1_W     = 33;                 // signed
    localparam int C2_W     = 25;                 // signed
    localparam int B0_W     = 36;                 // unsigned
    localparam int B1_W     = 30;                 // unsigned
    localparam int SQ_W     = 2 * TEMP_W;         // t*t and p*t
    localparam int C1T_W    = C1_W + TEMP_W + 1;  // signed
    localparam int B0P_W    = B0_W + BUTANE_W;
    localparam int C01_W    = C1T_W + 1;          // signed
    localparam int C2TT_W   = C2_W + SQ_W + 1;    // signed
    localparam int B1PT_W   = B1_W + SQ_W;
    localparam int POLY_W   = C01_W + 1;          // signed
    localparam int LPG_W    = B1PT_W + 1;
    localparam int SFULL_W  = POLY_W + 8;         // signed, poly*100 + lpg
    localparam int SCALE_W  = 48;                 // clamped scale, unsigned
    localparam int HALF_W   = SCALE_W / 2;
    localparam int PART_W   = ECHO_W + HALF_W;
    localparam int SUM_W    = PART_W + HALF_W + 1;
    localparam int FRAC_W   = 40;
    localparam int QF_W     = SUM_W - FRAC_W;
    localparam int Q_W      = 24;
    localparam int RECIP_W  = 25;
    localparam int RECIP_SH = 28;
    localparam int PROD_W   = Q_W + RECIP_W;

    // ------------------------------------------------------------------
    // Constants
    // ------------------------------------------------------------------
    localparam logic [ECHO_W-1:0]  EXT_OFFSET = ECHO_W'(16384);
    localparam logic [SUM_W-1:0]   ROUND_HALF = SUM_W'(5) << FRAC_W;
    localparam logic [QF_W-1:0]    SAT_Q      = QF_W'(10485760);
    localparam logic [RECIP_W-1:0] RECIP_TEN  = RECIP_W'(26843546);
    localparam logic [LEVEL_W-1:0] LEVEL_MAX  = '1;

    localparam logic [B0_W-1:0] BUTANE_B0 = 36'd39747345344;
    localparam logic [B1_W-1:0] BUTANE_B1 = 30'd896101977;

    // ------------------------------------------------------------------
    // Codes
    // ------------------------------------------------------------------
    typedef enum logic [2:0] {
        SET_NONE      = 3'd0,
        SET_WATER     = 3'd1,
        SET_LPG       = 3'd2,
        SET_GASOLINE  = 3'd3,
        SET_AIR       = 3'd4,
        SET_UNIVERSAL = 3'd5
    } t_set;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_BAD_HW    = 2'd1,
        ST_BAD_FLUID = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FLUID_KIND = 1'd0,
        CFG_BUTANE     = 1'd1
    } t_cfg_idx;

    // ------------------------------------------------------------------
    // Transaction payloads between stages
    // ------------------------------------------------------------------
    typedef struct packed {
        logic [HW_W-1:0]   hardware_id;
        logic              range_extended;
        logic [TEMP_W-1:0] temperature_code;
        logic [RAW_W-1:0]  raw_echo;
    } t_report;

    typedef struct packed {
        t_status                   status;
        logic                      lpg;
        logic [ECHO_W-1:0]         echo;
        logic signed [C0_W-1:0]    c0;
        logic signed [C1T_W-1:0]   c1t;
        logic signed [C2_W-1:0]    c2;
        logic [SQ_W-1:0]           tt;
        logic [SQ_W-1:0]           pt;
        logic [B0P_W-1:0]          b0p;
    } t_dec;

    typedef struct packed {
        t_status            status;
        logic [ECHO_W-1:0]  echo;
        logic [SCALE_W-1:0] scale;
    } t_scl;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        t_status            status;
    } t_result;

    // ------------------------------------------------------------------
    // Sensor model table: coefficient set per hardware id
    // ------------------------------------------------------------------
    function automatic t_set model_set(input logic [HW_W-1:0] hw);
        t_set s;
        unique case (hw)
            7'd3:                s = SET_LPG;
            7'd4, 7'd10, 7'd11:  s = SET_AIR;
            7'd5:                s = SET_WATER;
            7'd8, 7'd9, 7'd12:   s = SET_UNIVERSAL;
            default:             s = SET_NONE;
        endcase
        return s;
    endfunction

    // Fluid code to coefficient set for universal sensors
    function automatic t_set fluid_set(input logic [KIND_W-1:0] kind);
        t_set s;
        unique case (kind)
            4'd1, 4'd2, 4'd3, 4'd5, 4'd11: s = SET_WATER;
            4'd8:                          s = SET_LPG;
            4'd6, 4'd7:                    s = SET_GASOLINE;
            default:                       s = SET_NONE;
        endcase
        return s;
    endfunction

    function automatic logic signed [C0_W-1:0] coef_c0(input t_set s);
        logic signed [C0_W-1:0] c;
        unique case (s)
            SET_WATER:    c = 41'sd660357887549;
            SET_LPG:      c = 41'sd630069640739;
            SET_GASOLINE: c = 41'sd810715823592;
            SET_AIR:      c = 41'sd168330832166;
            default:      c = '0;
        endcase
        return c;
    endfunction

    function automatic logic signed [C1_W-1:0] coef_c1(input t_set s);
        logic signed [C1_W-1:0] c;
        unique case (s)
            SET_WATER:    c = 33'sd3434874325;
            SET_LPG:      c = -33'sd3102821814;
            SET_GASOLINE: c = -33'sd2175086761;
            SET_AIR:      c = 33'sd359540302;
            default:      c = '0;
        endcase
        return c;
    endfunction

    function automatic logic signed [C2_W-1:0] coef_c2(input t_set s);
        logic signed [C2_W-1:0] c;
        unique case (s)
            SET_WATER:    c = -25'sd15041319;
            SET_LPG:      c = -25'sd5882387;
            SET_GASOLINE: c = 25'sd2222795;
            SET_AIR:      c = -25'sd323256;
            default:      c = '0;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/tlc_report_if.sv
// ============================================================================
// tlc_report_if
// Valid/ready channel carrying one sensor report per transaction.
// ============================================================================
`default_nettype none

interface tlc_report_if
    import tlc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [HW_W-1:0]   hardware_id;
    logic              range_extended;
    logic [TEMP_W-1:0] temperature_code;
    logic [RAW_W-1:0]  raw_echo;

    modport source (
        output valid, hardware_id, range_extended, temperature_code, raw_echo,
        input  ready
    );

    modport sink (
        input  valid, hardware_id, range_extended, temperature_code, raw_echo,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/core/tlc_level_if.sv
// ============================================================================
// tlc_level_if
// Valid/ready channel carrying one compensated level result per transaction.
// ============================================================================
`default_nettype none

interface tlc_level_if
    import tlc_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [LEVEL_W-1:0]  level_hundredth_cm;
    logic [STATUS_W-1:0] status;

    modport source (
        output valid, level_hundredth_cm, status,
        input  ready
    );

    modport sink (
        input  valid, level_hundredth_cm, status,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/core/tlc_decode.sv
// ============================================================================
// tlc_decode
// First pipeline stage: model lookup, fluid selection, status, echo
// expansion and the first-level products (t*t, p*t, C1*t, B0*p).
// ============================================================================
`default_nettype none

module tlc_decode
    import tlc_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic [KIND_W-1:0]   i_fluid_kind,
    input  wire logic [BUTANE_W-1:0] i_butane_percent,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire t_report             i_data,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output t_dec                     o_data
);

    logic r_vld;
    t_dec r_dec;
    t_dec n_dec;
    logic adv;

    // Stage advances when empty or when downstream takes it
    assign adv     = !r_vld || i_ready;
    assign o_ready = adv;
    assign o_valid = r_vld;
    assign o_data  = r_dec;

    // Decode the report and form first products
    always_comb begin
        t_set set_hw;
        t_set set_eff;
        set_hw  = model_set(i_data.hardware_id);
        set_eff = (set_hw == SET_UNIVERSAL) ? fluid_set(i_fluid_kind) : set_hw;

        if (set_hw == SET_NONE) begin
            n_dec.status = ST_BAD_HW;
        end else if (set_eff == SET_NONE) begin
            n_dec.status = ST_BAD_FLUID;
        end else begin
            n_dec.status = ST_OK;
        end

        n_dec.lpg = (set_eff == SET_LPG);

        // Extended range: 4 us steps above the offset
        if (i_data.range_extended) begin
            n_dec.echo = EXT_OFFSET + {1'b0, i_data.raw_echo, 2'b00};
        end else begin
            n_dec.echo = {3'b000, i_data.raw_echo};
        end

        n_dec.c0  = coef_c0(set_eff);
        n_dec.c1t = coef_c1(set_eff) * $signed({1'b0, i_data.temperature_code});
        n_dec.c2  = coef_c2(set_eff);
        n_dec.tt  = i_data.temperature_code * i_data.temperature_code;
        n_dec.pt  = i_butane_percent * i_data.temperature_code;
        n_dec.b0p = BUTANE_B0 * i_butane_percent;
    end

    // Valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (adv) begin
            r_vld <= i_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dec <= n_dec;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/tlc_scale.sv
// ============================================================================
// tlc_scale
// Three pipeline stages that finish the temperature quadratic, add the
// butane correction for LPG, scale by 100 and clamp the result at zero.
// ============================================================================
`default_nettype none

module tlc_scale
    import tlc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_dec i_data,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_scl      o_data
);

    typedef struct packed {
        t_status                  status;
        logic                     lpg;
        logic [ECHO_W-1:0]        echo;
        logic signed [C01_W-1:0]  c01;
        logic signed [C2TT_W-1:0] c2tt;
        logic [B0P_W-1:0]         b0p;
        logic [B1PT_W-1:0]        b1pt;
    } t_st2;

    typedef struct packed {
        t_status                  status;
        logic [ECHO_W-1:0]        echo;
        logic signed [POLY_W-1:0] poly;
        logic [LPG_W-1:0]         lpg_sum;
    } t_st3;

    logic r_vld2, r_vld3, r_vld4;
    logic adv2, adv3, adv4;
    t_st2 r_st2, n_st2;
    t_st3 r_st3, n_st3;
    t_scl r_st4, n_st4;

    // Per-stage advance: a stage moves when empty or when the next one moves
    assign adv4    = !r_vld4 || i_ready;
    assign adv3    = !r_vld3 || adv4;
    assign adv2    = !r_vld2 || adv3;
    assign o_ready = adv2;
    assign o_valid = r_vld4;
    assign o_data  = r_st4;

    // Second products and the constant plus linear term
    always_comb begin
        n_st2.status = i_data.status;
        n_st2.lpg    = i_data.lpg;
        n_st2.echo   = i_data.echo;
        n_st2.c01    = C01_W'(i_data.c0) + C01_W'(i_data.c1t);
        n_st2.c2tt   = i_data.c2 * $signed({1'b0, i_data.tt});
        n_st2.b0p    = i_data.b0p;
        n_st2.b1pt   = BUTANE_B1 * i_data.pt;
    end

    // Quadratic sum and butane correction
    always_comb begin
        n_st3.status  = r_st2.status;
        n_st3.echo    = r_st2.echo;
        n_st3.poly    = POLY_W'(r_st2.c01) + POLY_W'(r_st2.c2tt);
        n_st3.lpg_sum = r_st2.lpg ? (LPG_W'(r_st2.b0p) + LPG_W'(r_st2.b1pt)) : '0;
    end

    // Scale by 100 (64 + 32 + 4), add correction, clamp negative to zero
    always_comb begin
        logic signed [SFULL_W-1:0] wide;
        logic signed [SFULL_W-1:0] s_full;
        wide   = SFULL_W'(r_st3.poly);
        s_full = (wide <<< 6) + (wide <<< 5) + (wide <<< 2)
                 + $signed(SFULL_W'(r_st3.lpg_sum));
        n_st4.status = r_st3.status;
        n_st4.echo   = r_st3.echo;
        n_st4.scale  = s_full[SFULL_W-1] ? '0 : s_full[SCALE_W-1:0];
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
        end else begin
            if (adv2) begin
                r_vld2 <= i_valid;
            end
            if (adv3) begin
                r_vld3 <= r_vld2;
            end
            if (adv4) begin
                r_vld4 <= r_vld3;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (adv2) begin
            r_st2 <= n_st2;
        end
        if (adv3) begin
            r_st3 <= n_st3;
        end
        if (adv4) begin
            r_st4 <= n_st4;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/tlc_level.sv
// ============================================================================
// tlc_level
// Four pipeline stages: echo times scale as two partial products, rounding
// and removal of the fraction bits, division by ten through a reciprocal
// multiply, then saturation and error masking into the output register.
// ============================================================================
`default_nettype none

module tlc_level
    import tlc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_scl i_data,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_result   o_data
);

    typedef struct packed {
        t_status           status;
        logic [PART_W-1:0] p_lo;
        logic [PART_W-1:0] p_hi;
    } t_st5;

    typedef struct packed {
        t_status        status;
        logic           sat;
        logic [Q_W-1:0] q;
    } t_st6;

    typedef struct packed {
        t_status           status;
        logic              sat;
        logic [PROD_W-1:0] prod;
    } t_st7;

    logic    r_vld5, r_vld6, r_vld7, r_vld8;
    logic    adv5, adv6, adv7, adv8;
    t_st5    r_st5, n_st5;
    t_st6    r_st6, n_st6;
    t_st7    r_st7, n_st7;
    t_result r_st8, n_st8;

    // Per-stage advance; the last stage is the output register
    assign adv8    = !r_vld8 || i_ready;
    assign adv7    = !r_vld7 || adv8;
    assign adv6    = !r_vld6 || adv7;
    assign adv5    = !r_vld5 || adv6;
    assign o_ready = adv5;
    assign o_valid = r_vld8;
    assign o_data  = r_st8;

    // Partial products on the low and high halves of the scale
    always_comb begin
        n_st5.status = i_data.status;
        n_st5.p_lo   = i_data.echo * i_data.scale[HALF_W-1:0];
        n_st5.p_hi   = i_data.echo * i_data.scale[SCALE_W-1:HALF_W];
    end

    // Combine, round by half of ten units, drop the fraction bits
    always_comb begin
        logic [SUM_W-1:0] sum;
        logic [QF_W-1:0]  q_full;
        sum    = (SUM_W'(r_st5.p_hi) << HALF_W) + SUM_W'(r_st5.p_lo) + ROUND_HALF;
        q_full = sum[SUM_W-1:FRAC_W];
        n_st6.status = r_st5.status;
        n_st6.sat    = (q_full >= SAT_Q);
        n_st6.q      = q_full[Q_W-1:0];
    end

    // Divide by ten: multiply by the rounded-up reciprocal
    always_comb begin
        n_st7.status = r_st6.status;
        n_st7.sat    = r_st6.sat;
        n_st7.prod   = r_st6.q * RECIP_TEN;
    end

    // Saturate and zero the level on error
    always_comb begin
        n_st8.status = r_st7.status;
        if (r_st7.status != ST_OK) begin
            n_st8.level = '0;
        end else if (r_st7.sat) begin
            n_st8.level = LEVEL_MAX;
        end else begin
            n_st8.level = r_st7.prod[RECIP_SH +: LEVEL_W];
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld5 <= 1'b0;
            r_vld6 <= 1'b0;
            r_vld7 <= 1'b0;
            r_vld8 <= 1'b0;
        end else begin
            if (adv5) begin
                r_vld5 <= i_valid;
            end
            if (adv6) begin
                r_vld6 <= r_vld5;
            end
            if (adv7) begin
                r_vld7 <= r_vld6;
            end
            if (adv8) begin
                r_vld8 <= r_vld7;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (adv5) begin
            r_st5 <= n_st5;
        end
        if (adv6) begin
            r_st6 <= n_st6;
        end
        if (adv7) begin
            r_st7 <= n_st7;
        end
        if (adv8) begin
            r_st8 <= n_st8;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/ultrasonic_tank_level_compensation_core.sv
// ----------------------------------------------------------------------------
// Usage
//   i_report (sink): one sensor report per transaction (hardware id,
//   range-extension bit, temperature code, raw echo time).
//   o_level (source): one result per report, in order: level in 0.01 cm
//   (saturating) and a status code (ok, unknown hardware, bad fluid).
//   Config port: i_cfg_we writes i_cfg_data into register i_cfg_index
//   (0 fluid kind, 1 butane percent); write only while the pipe is empty.
//   Pipeline: one decode stage, three scale stages, four level stages, the
//   last one being the output register. Throughput: one report per cycle
//   while the receiver keeps o_level.ready high.
//   Reset (synchronous, active low) empties every stage and clears both
//   config registers to zero.
//   When the receiver stalls, the result holds in the output register and
//   the empty stages behind it keep filling; i_report.ready drops only once
//   every stage holds a transaction.
// ----------------------------------------------------------------------------
// ============================================================================
// ultrasonic_tank_level_compensation_core
// Temperature-compensated tank level from ultrasonic echo time.
// ============================================================================
`default_nettype none

module ultrasonic_tank_level_compensation_core
    import tlc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    tlc_report_if.sink                 i_report,
    tlc_level_if.source                o_level
);

    logic [KIND_W-1:0]   r_fluid_kind;
    logic [BUTANE_W-1:0] r_butane_percent;

    t_report rpt;
    logic    dec_vld, dec_rdy;
    t_dec    dec_data;
    logic    scl_vld, scl_rdy;
    t_scl    scl_data;
    t_result res_data;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fluid_kind     <= '0;
            r_butane_percent <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_FLUID_KIND: r_fluid_kind     <= i_cfg_data[KIND_W-1:0];
                CFG_BUTANE:     r_butane_percent <= i_cfg_data[BUTANE_W-1:0];
            endcase
        end
    end

    // Gather the report fields
    assign rpt.hardware_id      = i_report.hardware_id;
    assign rpt.range_extended   = i_report.range_extended;
    assign rpt.temperature_code = i_report.temperature_code;
    assign rpt.raw_echo         = i_report.raw_echo;

    tlc_decode u_decode (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_fluid_kind     (r_fluid_kind),
        .i_butane_percent (r_butane_percent),
        .i_valid          (i_report.valid),
        .o_ready          (i_report.ready),
        .i_data           (rpt),
        .o_valid          (dec_vld),
        .i_ready          (dec_rdy),
        .o_data           (dec_data)
    );

    tlc_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (dec_vld),
        .o_ready (dec_rdy),
        .i_data  (dec_data),
        .o_valid (scl_vld),
        .i_ready (scl_rdy),
        .o_data  (scl_data)
    );

    tlc_level u_level (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (scl_vld),
        .o_ready (scl_rdy),
        .i_data  (scl_data),
        .o_valid (o_level.valid),
        .i_ready (o_level.ready),
        .o_data  (res_data)
    );

    // Drive the result channel
    assign o_level.level_hundredth_cm = res_data.level;
    assign o_level.status             = res_data.status;

endmodule

`default_nettype wire

FILE: rtl/core/tlc_checker.sv
// ============================================================================
// tlc_checker
// Port-level checks on the level compensation core, bound to the top level.
// ============================================================================
`default_nettype none

module tlc_checker
    import tlc_pkg::*;
(
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_ready,
    input wire logic                i_out_valid,
    input wire logic                i_out_ready,
    input wire logic [LEVEL_W-1:0]  i_level,
    input wire logic [STATUS_W-1:0] i_status
);

    // Reset empties the pipe: no result right after a reset edge
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // A stalled result holds steady
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_level)
                                        && $stable(i_status))
        else $error("stalled result changed or vanished");

    // Error results carry a zero level
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status != ST_OK) |-> (i_level == '0))
        else $error("error result with nonzero level");

    // With the output register empty, no stage can block a new report
    a_no_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled while output is empty");

endmodule

bind ultrasonic_tank_level_compensation_core tlc_checker u_tlc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_report.ready),
    .i_out_valid (o_level.valid),
    .i_out_ready (o_level.ready),
    .i_level     (o_level.level_hundredth_cm),
    .i_status    (o_level.status)
);

`default_nettype wire
